[rtl/lwr_pkg.sv]
// ----------------------------------------------------------------------------
// lwr_pkg
// Shared types, constants and helpers for the layer weight store.
// ----------------------------------------------------------------------------
package lwr_pkg;

  localparam int MAX_SIDE         = 256;
  localparam int GROUPS           = 2;
  localparam int LAYERS_PER_GROUP = 4;
  localparam int NUM_LAYERS       = GROUPS * LAYERS_PER_GROUP;
  localparam int LAYER_W          = 3;
  localparam int WORD_W           = 64;
  localparam int SIDE_W           = 9;
  localparam int COORD_W          = 10;
  localparam int DEPTH            = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W           = $clog2(DEPTH);
  localparam int SUM_W            = 11;
  localparam int NUM_W            = 26;
  localparam int DEN_W            = 20;

  localparam logic [WORD_W-1:0] RESET_WORD = 64'h00000000_000000FF;

  localparam logic [1:0] CMD_APPLY = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;

  localparam logic [1:0] CFG_GRID_SIDE = 2'd0;
  localparam logic [1:0] CFG_NORMALIZE = 2'd1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_LOAD,
    ST_DEC,
    ST_NUM,
    ST_DIVW,
    ST_WB,
    ST_OUT
  } state_t;

  // floor(n / 257) for n < 65792 via reciprocal multiply
  function automatic logic [7:0] div257(input logic [16:0] n);
    logic [33:0] p;
    p = {17'd0, n} * 34'd65281;
    return p[31:24];
  endfunction

  function automatic logic [SIDE_W-1:0] side_in_use(input logic [SIDE_W-1:0] v);
    if (v < SIDE_W'(2)) return SIDE_W'(2);
    if (v > SIDE_W'(MAX_SIDE)) return SIDE_W'(MAX_SIDE);
    return v;
  endfunction

endpackage

[rtl/lwr_ram.sv]
// ----------------------------------------------------------------------------
// lwr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lwr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/lwr_div.sv]
// ----------------------------------------------------------------------------
// lwr_div
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
// ----------------------------------------------------------------------------
module lwr_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lwr_pkg::NUM_W-1:0]  num,
  input  logic [lwr_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [7:0]                 quo
);
  import lwr_pkg::*;

  localparam int DSH_W = DEN_W + 8;

  logic [NUM_W-1:0] rem;
  logic [DSH_W-1:0] dsh;
  logic [2:0]       cnt;
  logic             running;
  logic             ge;

  assign ge = {{(DSH_W-NUM_W){1'b0}}, rem} >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= 3'd0;
        rem     <= num;
        dsh     <= {1'b0, den, 7'd0};
        quo     <= 8'd0;
      end else if (running) begin
        if (ge) begin
          rem <= rem - NUM_W'(dsh);
        end
        quo <= {quo[6:0], ge};
        dsh <= dsh >> 1;
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/layer_weight_renormalize_store_core.sv]
// ----------------------------------------------------------------------------
// layer_weight_renormalize_store_core
// Per-sample layer weight store with apply/renormalize, write and read.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive cmd, coord_x, coord_z, layer_sel, value_q16 and
//   pulse start while busy is low. Exactly one result follows per request
//   unless a side change drops it; weight_byte and status are valid for the
//   single done cycle. The receiver cannot stall; it waits on nothing downstream.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Index 0 is grid_side, index 1 normalize_en.
// Per request: an ignored (out-of-grid) write or apply goes straight to ST_OUT;
//   read runs ST_RD, ST_LOAD, ST_DEC, ST_OUT; write and plain apply add ST_WB;
//   renormalizing apply runs seven divisions on one shared divider (ST_NUM,
//   ST_DIVW per layer, stepping over the target layer). One request at a time.
// Reset: the 65536-word store is cleared by a sweep, one word a cycle,
//   with busy high. A grid_side write that changes the side in use
//   starts the same sweep.
// ----------------------------------------------------------------------------
module layer_weight_renormalize_store_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          cmd,
  input  logic signed [lwr_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [lwr_pkg::COORD_W-1:0]  coord_z,
  input  logic [lwr_pkg::LAYER_W-1:0]         layer_sel,
  input  logic [15:0]                         value_q16,
  output logic                                done,
  output logic [7:0]                          weight_byte,
  output logic                                status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [lwr_pkg::SIDE_W-1:0]          cfg_data
);
  import lwr_pkg::*;

  state_t state, state_next;

  logic [SIDE_W-1:0]  grid_side;
  logic               normalize_en;
  logic [SIDE_W-1:0]  side;
  logic               side_change;

  logic [1:0]         cmd_r;
  logic [LAYER_W-1:0] layer_r;
  logic [15:0]        v_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [ADDR_W-1:0]  clr_cnt;
  logic [WORD_W-1:0]  word;
  logic [SUM_W-1:0]   sum;
  logic [LAYER_W-1:0] l;

  logic               accept;
  logic               outside;
  logic [7:0]         cx, cz;
  logic [16:0]        addr_calc;
  logic [SUM_W-1:0]   sum_calc;
  logic [7:0]         t;
  logic [7:0]         fill0;
  logic [15:0]        rest;
  logic               is_read;
  logic               do_norm;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;

  logic               div_start, div_done;
  logic [7:0]         div_quo;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [7:0]         w_cur;

  assign side      = side_in_use(grid_side);
  assign cfg_ready = 1'b1;
  assign side_change = cfg_valid && cfg_index == CFG_GRID_SIDE &&
                       side_in_use(cfg_data) != side;
  assign busy   = state != ST_IDLE;
  assign accept = start && !busy;

  // coordinate checks and clamping
  always_comb begin
    outside = coord_x < 0 || coord_z < 0 ||
              coord_x >= $signed({1'b0, side}) || coord_z >= $signed({1'b0, side});
    if (coord_x < 0) begin
      cx = 8'd0;
    end else if (coord_x >= $signed({1'b0, side})) begin
      cx = 8'(side - SIDE_W'(1));
    end else begin
      cx = coord_x[7:0];
    end
    if (coord_z < 0) begin
      cz = 8'd0;
    end else if (coord_z >= $signed({1'b0, side})) begin
      cz = 8'(side - SIDE_W'(1));
    end else begin
      cz = coord_z[7:0];
    end
    addr_calc = 17'({9'd0, cz} * {8'd0, side}) + 17'(cx);
  end

  always_comb begin
    sum_calc = '0;
    for (int i = 0; i < NUM_LAYERS; i++) begin
      if (LAYER_W'(i) != layer_r) begin
        sum_calc = sum_calc + SUM_W'(ram_rdata[i*8 +: 8]);
      end
    end
  end

  assign is_read = cmd_r[1];
  assign do_norm = cmd_r == CMD_APPLY && normalize_en;
  assign rest    = ~v_r;
  assign t       = div257(17'(v_r) + 17'd128);
  assign fill0   = div257(17'(rest) + 17'd128);
  assign w_cur   = word[l*8 +: 8];
  assign div_num = NUM_W'({24'(w_cur) * 24'(rest), 1'b0}) + NUM_W'(sum) * NUM_W'(257);
  assign div_den = DEN_W'(sum) * DEN_W'(514);

  lwr_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  lwr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // next state
  always_comb begin
    state_next = state;
    if (side_change) begin
      state_next = ST_CLEAR;
    end else begin
      unique case (state)
        ST_CLEAR: if (clr_cnt == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
        ST_IDLE: begin
          if (accept) begin
            state_next = (!cmd[1] && outside) ? ST_OUT : ST_RD;
          end
        end
        ST_RD:   state_next = ST_LOAD;
        ST_LOAD: state_next = ST_DEC;
        ST_DEC: begin
          if (is_read) begin
            state_next = ST_OUT;
          end else if (do_norm && sum != '0) begin
            state_next = ST_NUM;
          end else begin
            state_next = ST_WB;
          end
        end
        ST_NUM: begin
          if (l != layer_r) begin
            state_next = ST_DIVW;
          end else if (l == LAYER_W'(NUM_LAYERS - 1)) begin
            state_next = ST_WB;
          end
        end
        ST_DIVW: begin
          if (div_done) begin
            state_next = (l == LAYER_W'(NUM_LAYERS - 1)) ? ST_WB : ST_NUM;
          end
        end
        ST_WB:  state_next = ST_OUT;
        ST_OUT: state_next = ST_IDLE;
        default: state_next = ST_IDLE;
      endcase
    end
  end

  // outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = word;
    div_start = 1'b0;
    done      = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = RESET_WORD;
      end
      ST_RD:  ram_re = 1'b1;
      ST_NUM: div_start = l != layer_r;
      ST_WB: begin
        ram_we = 1'b1;
        ram_wdata[layer_r*8 +: 8] = t;
      end
      ST_OUT: done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      grid_side    <= SIDE_W'(MAX_SIDE);
      normalize_en <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_index == CFG_GRID_SIDE) begin
        grid_side <= cfg_data;
      end
      if (cfg_valid && cfg_index == CFG_NORMALIZE) begin
        normalize_en <= cfg_data[0];
      end
      if (side_change) begin
        clr_cnt <= '0;
      end else if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd_r       <= cmd;
          layer_r     <= layer_sel;
          v_r         <= value_q16;
          addr_r      <= addr_calc[ADDR_W-1:0];
          weight_byte <= 8'd0;
          status      <= !cmd[1] && outside;
        end
      end
      ST_LOAD: begin
        word <= ram_rdata;
        sum  <= sum_calc;
        l    <= '0;
      end
      ST_DEC: begin
        if (is_read) begin
          weight_byte <= word[layer_r*8 +: 8];
        end else if (do_norm && sum == '0 && layer_r != '0) begin
          word[7:0] <= fill0;
        end
      end
      ST_NUM: begin
        if (l == layer_r && l != LAYER_W'(NUM_LAYERS - 1)) begin
          l <= l + LAYER_W'(1);
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          word[l*8 +: 8] <= div_quo;
          if (l != LAYER_W'(NUM_LAYERS - 1)) begin
            l <= l + LAYER_W'(1);
          end
        end
      end
      ST_WB: weight_byte <= t;
      default: ;
    endcase
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result outside a request");

  a_clear_word: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == ST_CLEAR) |-> ram_wdata == RESET_WORD)
    else $error("clear sweep wrote wrong word");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == ST_DIVW || state == ST_CLEAR)
    else $error("divider started outside renormalize");

endmodule
